// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, derived widths, character codes, operation codes and the
// cursor command and status bundles shared by the sequencer and the cursor unit.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    // TAB_STOP is a power of two, so the tab phase is the low bits of a position.
    localparam int TAB_STOP = 8;
    localparam int CELLS    = COLUMNS * ROWS;

    // Port widths of the item fields.
    localparam int FUNC_W     = 3;
    localparam int CHAR_W     = 8;
    localparam int IN_COL_W   = 7;
    localparam int IN_ROW_W   = 5;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;

    // Internal widths follow the geometry.
    localparam int CW  = $clog2(COLUMNS);
    localparam int RW  = $clog2(ROWS);
    localparam int AW  = $clog2(CELLS);
    localparam int PHW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

    // Tab phase of the last row start, where the cursor lands after a scroll.
    localparam int SCROLL_PHASE = (CELLS - COLUMNS) % TAB_STOP;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    // Operation codes of the func field; the remaining codes do nothing.
    typedef enum logic [FUNC_W-1:0] {
        FN_PRINT      = 3'd0,
        FN_SET_CURSOR = 3'd1,
        FN_CLEAR      = 3'd2,
        FN_WRITE_CELL = 3'd3,
        FN_READ_CELL  = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        CUR_NONE,
        CUR_ZERO,
        CUR_STEP,
        CUR_HOME,
        CUR_LOAD
    } t_cur_op;

    typedef struct packed {
        t_cur_op         op;
        logic [CW-1:0]   col;
        logic [RW-1:0]   row;
        logic [AW-1:0]   pos;
    } t_cur_cmd;

    typedef struct packed {
        logic [CW-1:0]   col;
        logic [RW-1:0]   row;
        logic [AW-1:0]   pos;
        logic            line_end;
        logic            tab_end;
        logic            at_end;
    } t_cur_stat;

endpackage

// ===== rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// Text console writer
// Teletype text engine over an 80 by 25 character store with a cursor.
// ----------------------------------------------------------------------------
// The block handles one item at a time and holds o_in_stall high until its
// result is loaded into the output register. After reset the store is swept
// to spaces, one cell a cycle, before the first item is taken. An item
// passes through the address, execute and done states; read cell adds a read
// state before done. A newline or tab walks the cursor one cell a cycle
// through the cursor unit. A scroll copies the store one cell a cycle through
// the single memory port pair and refills the last row; clear screen sweeps
// every cell to spaces.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic [IN_COL_W-1:0]  i_column,
    input  logic [IN_ROW_W-1:0]  i_row,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [OUT_COL_W-1:0] o_cursor_column,
    output logic [OUT_ROW_W-1:0] o_cursor_row,
    output logic [CHAR_W-1:0]    o_cell_char,
    output logic                 o_scrolled
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR,
        S_EXEC,
        S_STEP,
        S_SCROLL,
        S_FILL,
        S_READ,
        S_DONE
    } t_state;

    t_state               r_state;
    logic                 r_item;
    t_func                r_func;
    logic [CHAR_W-1:0]    r_char;
    logic [IN_COL_W-1:0]  r_in_col;
    logic [IN_ROW_W-1:0]  r_in_row;
    logic [CW-1:0]        r_sat_col;
    logic [RW-1:0]        r_sat_row;
    logic [AW-1:0]        r_addr;
    logic                 r_inside;
    logic [AW-1:0]        r_cnt;
    logic                 r_cp_pend;
    logic [AW-1:0]        r_cp_addr;
    logic [CHAR_W-1:0]    r_cell;
    logic                 r_scr;

    logic                 r_out_valid;
    logic [OUT_COL_W-1:0] r_out_col;
    logic [OUT_ROW_W-1:0] r_out_row;
    logic [CHAR_W-1:0]    r_out_cell;
    logic                 r_out_scr;

    logic [CW-1:0]        sat_col;
    logic [RW-1:0]        sat_row;
    logic                 plain_char;
    logic                 is_newline;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [CHAR_W-1:0]    mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [CHAR_W-1:0]    mem_rdata;
    t_cur_cmd             cur_cmd;
    t_cur_stat            cur_stat;

    assign is_newline = (r_char == CH_NEWLINE);
    assign plain_char = !is_newline && (r_char != CH_TAB);

    // Out-of-range coordinates saturate to the last column and row.
    always_comb begin
        if (32'(r_in_col) >= 32'(COLUMNS)) begin
            sat_col = CW'(COLUMNS - 1);
        end else begin
            sat_col = CW'(r_in_col);
        end
        if (32'(r_in_row) >= 32'(ROWS)) begin
            sat_row = RW'(ROWS - 1);
        end else begin
            sat_row = RW'(r_in_row);
        end
    end

    always_comb begin
        cur_cmd.op  = CUR_NONE;
        cur_cmd.col = r_sat_col;
        cur_cmd.row = r_sat_row;
        cur_cmd.pos = r_addr;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = r_char;
        mem_raddr   = r_addr;
        case (r_state)
            S_EXEC: begin
                case (r_func)
                    FN_PRINT: begin
                        if (plain_char) begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_stat.pos;
                            cur_cmd.op = cur_stat.at_end ? CUR_HOME : CUR_STEP;
                        end
                    end
                    FN_SET_CURSOR: cur_cmd.op = CUR_LOAD;
                    FN_CLEAR:      cur_cmd.op = CUR_ZERO;
                    FN_WRITE_CELL: mem_we = r_inside;
                    default: begin
                    end
                endcase
            end
            S_STEP: begin
                cur_cmd.op = cur_stat.at_end ? CUR_HOME : CUR_STEP;
            end
            S_SCROLL: begin
                // Read one row below while the previous read lands one row up.
                mem_raddr = AW'(32'(r_cnt) + 32'(COLUMNS));
                mem_we    = r_cp_pend;
                mem_waddr = r_cp_addr;
                mem_wdata = mem_rdata;
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = CH_SPACE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_item      <= 1'b0;
            r_cnt       <= '0;
            r_cp_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A result loaded in S_DONE keeps the output register full.
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func   <= t_func'(i_func);
                        r_char   <= i_char_code;
                        r_in_col <= i_column;
                        r_in_row <= i_row;
                        r_cell   <= '0;
                        r_scr    <= 1'b0;
                        r_item   <= 1'b1;
                        r_state  <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_sat_col <= sat_col;
                    r_sat_row <= sat_row;
                    r_addr    <= AW'(32'(sat_row) * 32'(COLUMNS) + 32'(sat_col));
                    r_inside  <= (32'(r_in_col) < 32'(COLUMNS)) &&
                                 (32'(r_in_row) < 32'(ROWS));
                    r_state   <= S_EXEC;
                end
                S_EXEC: begin
                    case (r_func)
                        FN_PRINT: begin
                            if (!plain_char) begin
                                r_state <= S_STEP;
                            end else if (cur_stat.at_end) begin
                                r_scr   <= 1'b1;
                                r_cnt   <= '0;
                                r_state <= S_SCROLL;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        FN_SET_CURSOR: r_state <= S_DONE;
                        FN_CLEAR: begin
                            r_cnt   <= '0;
                            r_state <= S_FILL;
                        end
                        FN_READ_CELL: r_state <= r_inside ? S_READ : S_DONE;
                        default:      r_state <= S_DONE;
                    endcase
                end
                S_STEP: begin
                    if (cur_stat.at_end) begin
                        r_scr   <= 1'b1;
                        r_cnt   <= '0;
                        r_state <= S_SCROLL;
                    end else if (is_newline ? cur_stat.line_end : cur_stat.tab_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_SCROLL: begin
                    r_cp_pend <= (r_cnt < AW'(CELLS - COLUMNS));
                    r_cp_addr <= r_cnt;
                    if (r_cnt == AW'(CELLS - COLUMNS)) begin
                        r_state <= S_FILL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FILL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == AW'(CELLS - 1)) begin
                        r_state <= r_item ? S_DONE : S_IDLE;
                    end
                end
                S_READ: begin
                    r_cell  <= mem_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_col   <= OUT_COL_W'(cur_stat.col);
                        r_out_row   <= OUT_ROW_W'(cur_stat.row);
                        r_out_cell  <= r_cell;
                        r_out_scr   <= r_scr;
                        r_item      <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    tcw_screen_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tcw_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cur_cmd),
        .o_stat  (cur_stat)
    );

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cursor_column = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_cell_char     = r_out_cell;
    assign o_scrolled      = r_out_scr;

endmodule

// ===== rtl/tcw_screen_mem.sv =====
// ----------------------------------------------------------------------------
// Character store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_screen_mem
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [CHAR_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [CHAR_W-1:0] o_rdata
);

    logic [CHAR_W-1:0] r_mem [CELLS];
    logic [CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcw_cursor.sv =====
// ----------------------------------------------------------------------------
// Cursor unit
// Holds the cursor as column, row, linear position and tab phase, and
// advances it one cell per step. A loaded position takes its tab phase from
// the low bits of the position.
// ----------------------------------------------------------------------------
module tcw_cursor
    import tcw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cur_cmd  i_cmd,
    output t_cur_stat o_stat
);

    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [AW-1:0]  r_pos;
    logic [PHW-1:0] r_phase;

    logic           line_end;

    assign line_end = (r_col == CW'(COLUMNS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_pos   <= '0;
            r_phase <= '0;
        end else begin
            case (i_cmd.op)
                CUR_ZERO: begin
                    r_col   <= '0;
                    r_row   <= '0;
                    r_pos   <= '0;
                    r_phase <= '0;
                end
                CUR_STEP: begin
                    r_pos <= r_pos + 1'b1;
                    if (line_end) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    if (r_phase == PHW'(TAB_STOP - 1)) begin
                        r_phase <= '0;
                    end else begin
                        r_phase <= r_phase + 1'b1;
                    end
                end
                CUR_HOME: begin
                    r_col   <= '0;
                    r_row   <= RW'(ROWS - 1);
                    r_pos   <= AW'(CELLS - COLUMNS);
                    r_phase <= PHW'(SCROLL_PHASE);
                end
                CUR_LOAD: begin
                    r_col   <= i_cmd.col;
                    r_row   <= i_cmd.row;
                    r_pos   <= i_cmd.pos;
                    r_phase <= PHW'(i_cmd.pos % AW'(TAB_STOP));
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_stat.col      = r_col;
        o_stat.row      = r_row;
        o_stat.pos      = r_pos;
        o_stat.line_end = line_end;
        o_stat.tab_end  = (r_phase == PHW'(TAB_STOP - 1));
        o_stat.at_end   = line_end && (r_row == RW'(ROWS - 1));
    end

endmodule

// ===== tb/tb_text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Sends console operations through the input handshake and keeps its own copy
// of the screen and cursor. Each result is checked against that copy in
// order. A short directed part covers reset contents, printing, tabs,
// newlines, scrolls, cell access, unknown codes and clearing. A random part
// follows, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int    CLK_PERIOD     = 8;
    localparam longint TIMEOUT_CYCLES = 20_000_000;
    localparam int    RANDOM_SEGMENTS = 16;
    localparam int    SEGMENT_ITEMS   = 100;

    localparam logic [FUNC_W-1:0] OP_PRINT      = FN_PRINT;
    localparam logic [FUNC_W-1:0] OP_SET_CURSOR = FN_SET_CURSOR;
    localparam logic [FUNC_W-1:0] OP_CLEAR      = FN_CLEAR;
    localparam logic [FUNC_W-1:0] OP_WRITE_CELL = FN_WRITE_CELL;
    localparam logic [FUNC_W-1:0] OP_READ_CELL  = FN_READ_CELL;
    localparam logic [FUNC_W-1:0] OP_RSVD_LO    = 3'd5;
    localparam logic [FUNC_W-1:0] OP_RSVD_HI    = 3'd7;

    localparam logic [IN_COL_W-1:0] COL_MAX_IN = {IN_COL_W{1'b1}};
    localparam logic [IN_ROW_W-1:0] ROW_MAX_IN = {IN_ROW_W{1'b1}};

    typedef enum logic [1:0] {
        STALL_OFF,
        STALL_RANDOM,
        STALL_PATTERN
    } t_stall_mode;

    typedef struct packed {
        logic [OUT_COL_W-1:0] cursor_column;
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [CHAR_W-1:0]    cell_char;
        logic                 scrolled;
    } t_console_status;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [CHAR_W-1:0]    i_char_code = '0;
    logic [IN_COL_W-1:0]  i_column = '0;
    logic [IN_ROW_W-1:0]  i_row = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [OUT_COL_W-1:0] o_cursor_column;
    logic [OUT_ROW_W-1:0] o_cursor_row;
    logic [CHAR_W-1:0]    o_cell_char;
    logic                 o_scrolled;

    // Copy of the screen and cursor, advanced as each item is accepted.
    logic [CHAR_W-1:0] screen_copy [CELLS];
    int unsigned       cursor_copy;
    t_console_status   expected_status [$];

    int          error_count = 0;
    int          result_count = 0;
    bit          gaps_on = 1'b0;
    bit          sender_active = 1'b0;
    int unsigned burst_left = 0;
    t_stall_mode stall_mode = STALL_OFF;
    logic [15:0] stall_pattern = 16'h0000;
    logic [3:0]  stall_phase = 4'd0;

    text_console_writer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_char_code     (i_char_code),
        .i_column        (i_column),
        .i_row           (i_row),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row),
        .o_cell_char     (o_cell_char),
        .o_scrolled      (o_scrolled)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb: failure");
        $finish;
    end

    function automatic t_console_status apply_console_op(
        input logic [FUNC_W-1:0]   func,
        input logic [CHAR_W-1:0]   ch,
        input logic [IN_COL_W-1:0] col,
        input logic [IN_ROW_W-1:0] row
    );
        t_console_status res;
        int unsigned     pos;
        int unsigned     c;
        int unsigned     r;
        bit              on_screen;
        res = '0;
        c = 32'(col);
        r = 32'(row);
        on_screen = (c < COLUMNS) && (r < ROWS);
        case (func)
            OP_PRINT: begin
                pos = (cursor_copy < CELLS) ? cursor_copy : 0;
                if (ch == CH_NEWLINE) begin
                    pos += COLUMNS - pos % COLUMNS;
                end else if (ch == CH_TAB) begin
                    pos += TAB_STOP - pos % TAB_STOP;
                end else begin
                    screen_copy[pos] = ch;
                    pos++;
                end
                // Running off the end shifts every row up and blanks the last one.
                if (pos >= CELLS) begin
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen_copy[i] = screen_copy[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_copy[i] = CH_SPACE;
                    pos = CELLS - COLUMNS;
                    res.scrolled = 1'b1;
                end
                cursor_copy = pos;
            end
            OP_SET_CURSOR: begin
                if (c >= COLUMNS) c = COLUMNS - 1;
                if (r >= ROWS) r = ROWS - 1;
                cursor_copy = r * COLUMNS + c;
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_copy[i] = CH_SPACE;
                cursor_copy = 0;
            end
            OP_WRITE_CELL: begin
                if (on_screen) screen_copy[r * COLUMNS + c] = ch;
            end
            OP_READ_CELL: begin
                if (on_screen) res.cell_char = screen_copy[r * COLUMNS + c];
            end
            default: begin
            end
        endcase
        res.cursor_column = OUT_COL_W'(cursor_copy % COLUMNS);
        res.cursor_row    = OUT_ROW_W'(cursor_copy / COLUMNS);
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        if (error_count < 100) $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic issue_op(
        input logic [FUNC_W-1:0]   func,
        input logic [CHAR_W-1:0]   ch,
        input logic [IN_COL_W-1:0] col,
        input logic [IN_ROW_W-1:0] row
    );
        int unsigned gap;
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_char_code <= ch;
        i_column    <= col;
        i_row       <= row;
        sender_active = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        expected_status.push_back(apply_console_op(func, ch, col, row));
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 9);
                i_in_valid <= 1'b0;
                sender_active = 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic await_all_results();
        if (sender_active) begin
            i_in_valid <= 1'b0;
            sender_active = 1'b0;
        end
        while (expected_status.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 4'd1;
        case (stall_mode)
            STALL_RANDOM:  i_out_stall <= ($urandom_range(0, 2) == 0);
            STALL_PATTERN: i_out_stall <= stall_pattern[stall_phase];
            default:       i_out_stall <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin : check_results
        t_console_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_count++;
            if (expected_status.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with none pending", result_count));
            end else begin
                want = expected_status.pop_front();
                if (o_cursor_column !== want.cursor_column)
                    flag_mismatch($sformatf("result %0d cursor_column %0d, want %0d",
                                            result_count, o_cursor_column, want.cursor_column));
                if (o_cursor_row !== want.cursor_row)
                    flag_mismatch($sformatf("result %0d cursor_row %0d, want %0d",
                                            result_count, o_cursor_row, want.cursor_row));
                if (o_cell_char !== want.cell_char)
                    flag_mismatch($sformatf("result %0d cell_char %02h, want %02h",
                                            result_count, o_cell_char, want.cell_char));
                if (o_scrolled !== want.scrolled)
                    flag_mismatch($sformatf("result %0d scrolled %0b, want %0b",
                                            result_count, o_scrolled, want.scrolled));
            end
        end
    end

    task automatic test_reset_contents();
        issue_op(OP_READ_CELL, 8'h00, 7'd0, 5'd0);
        issue_op(OP_READ_CELL, 8'h00, IN_COL_W'(COLUMNS - 1), IN_ROW_W'(ROWS - 1));
    endtask

    task automatic test_print_cases();
        issue_op(OP_PRINT, 8'h41, 7'd0, 5'd0);
        issue_op(OP_PRINT, CH_TAB, 7'd0, 5'd0);
        issue_op(OP_PRINT, CH_NEWLINE, 7'd0, 5'd0);
        // A newline at a line start skips a whole line.
        issue_op(OP_PRINT, CH_NEWLINE, 7'd0, 5'd0);
        issue_op(OP_PRINT, 8'hFF, 7'd0, 5'd0);
    endtask

    task automatic test_cell_access();
        issue_op(OP_WRITE_CELL, 8'hFF, 7'd0, 5'd0);
        issue_op(OP_WRITE_CELL, 8'h00, IN_COL_W'(COLUMNS - 1), IN_ROW_W'(ROWS - 1));
        issue_op(OP_WRITE_CELL, 8'h11, COL_MAX_IN, ROW_MAX_IN);
        issue_op(OP_READ_CELL, 8'h00, 7'd0, 5'd0);
        issue_op(OP_READ_CELL, 8'h00, COL_MAX_IN, ROW_MAX_IN);
        issue_op(OP_READ_CELL, 8'h00, IN_COL_W'(COLUMNS), 5'd0);
    endtask

    task automatic test_cursor_and_scroll();
        // Out-of-range coordinates clamp to the last cell; printing there scrolls.
        issue_op(OP_SET_CURSOR, 8'h00, COL_MAX_IN, ROW_MAX_IN);
        issue_op(OP_PRINT, 8'h00, 7'd0, 5'd0);
        issue_op(OP_READ_CELL, 8'h00, IN_COL_W'(COLUMNS - 1), IN_ROW_W'(ROWS - 2));
        // A tab near a line end lands at the start of the next row.
        issue_op(OP_SET_CURSOR, 8'h00, IN_COL_W'(COLUMNS - 2), 5'd3);
        issue_op(OP_PRINT, CH_TAB, 7'd0, 5'd0);
        issue_op(OP_SET_CURSOR, 8'h00, IN_COL_W'(COLUMNS - 4), IN_ROW_W'(ROWS - 1));
        issue_op(OP_PRINT, CH_TAB, 7'd0, 5'd0);
        issue_op(OP_PRINT, CH_NEWLINE, 7'd0, 5'd0);
    endtask

    task automatic test_unknown_ops();
        issue_op(OP_RSVD_LO, 8'hFF, COL_MAX_IN, ROW_MAX_IN);
        issue_op(OP_RSVD_HI, 8'h00, 7'd5, 5'd5);
    endtask

    task automatic test_clear_screen();
        issue_op(OP_CLEAR, 8'hA5, 7'd3, 5'd3);
        issue_op(OP_READ_CELL, 8'h00, 7'd0, 5'd0);
    endtask

    task automatic send_random_op();
        int unsigned          pick;
        logic [FUNC_W-1:0]   func;
        logic [CHAR_W-1:0]   ch;
        logic [IN_COL_W-1:0] col;
        logic [IN_ROW_W-1:0] row;
        pick = $urandom_range(0, 99);
        if (pick < 55)      func = OP_PRINT;
        else if (pick < 67) func = OP_SET_CURSOR;
        else if (pick < 68) func = OP_CLEAR;
        else if (pick < 80) func = OP_WRITE_CELL;
        else if (pick < 95) func = OP_READ_CELL;
        else                func = FUNC_W'($urandom_range(32'(OP_RSVD_LO), 32'(OP_RSVD_HI)));
        case ($urandom_range(0, 9))
            0:       ch = CH_NEWLINE;
            1:       ch = CH_TAB;
            default: ch = CHAR_W'($urandom_range(0, 255));
        endcase
        // Mostly on-screen coordinates, with the full field range now and then.
        if ($urandom_range(0, 3) == 0) col = IN_COL_W'($urandom_range(0, 32'(COL_MAX_IN)));
        else                          col = IN_COL_W'($urandom_range(0, COLUMNS - 1));
        if ($urandom_range(0, 3) == 0) row = IN_ROW_W'($urandom_range(0, 32'(ROW_MAX_IN)));
        else                          row = IN_ROW_W'($urandom_range(0, ROWS - 1));
        issue_op(func, ch, col, row);
    endtask

    task automatic test_random_traffic();
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            if (seg == 0) begin
                gaps_on = 1'b0;
                stall_mode = STALL_OFF;
            end else begin
                gaps_on = ($urandom_range(0, 3) != 0);
                stall_mode = t_stall_mode'($urandom_range(0, 2));
                stall_pattern = 16'($urandom_range(0, 16'h7FFF));
            end
            for (int n = 0; n < SEGMENT_ITEMS; n++)
                send_random_op();
            if (seg % 4 == 3) await_all_results();
        end
    endtask

    initial begin : main
        for (int i = 0; i < CELLS; i++)
            screen_copy[i] = CH_SPACE;
        cursor_copy = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_contents();
        test_print_cases();
        gaps_on = 1'b1;
        stall_mode = STALL_RANDOM;
        test_cell_access();
        test_cursor_and_scroll();
        await_all_results();
        test_unknown_ops();
        test_clear_screen();
        test_random_traffic();

        await_all_results();
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && expected_status.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== text_console_writer.f =====
rtl/tcw_pkg.sv
rtl/tcw_screen_mem.sv
rtl/tcw_cursor.sv
rtl/text_console_writer.sv
tb/tb_text_console_writer.sv
